// ----- hdl/assert_macros.svh -----
// assertion macros shared by the line formatter modules
// depends on a clock named i_clk and an active-low reset named i_rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- hdl/tslf_pkg.sv -----
// types, constants and helper functions of the text stream line formatter
// no dependencies; used by every module of the block
`default_nettype none

package tslf_pkg;

    // line number layout
    localparam int NUMBER_DIGITS = 6;
    localparam int DIGIT_W       = NUMBER_DIGITS * 4;
    localparam int DIG_CNT_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    // bytes per request at most
    localparam int MAX_RESULTS = 12;
    localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_CTRL_LAST = 8'd31;
    localparam logic [7:0] CH_DEL       = 8'd127;
    localparam logic [7:0] CH_NP_LAST   = 8'd159;
    localparam logic [7:0] CH_HIGH_BIT  = 8'h80;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_NUMBER_ALL       = 3'd0,
        CFG_NUMBER_NONBLANK  = 3'd1,
        CFG_SHOW_ENDS        = 3'd2,
        CFG_SHOW_NONPRINTING = 3'd3,
        CFG_SQUEEZE_BLANK    = 3'd4,
        CFG_SHOW_TABS        = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic show_ends;
        logic show_nonprinting;
        logic squeeze_blank;
        logic show_tabs;
    } t_cfg;

    // one classified request as the back end carries it out
    typedef struct packed {
        logic               has_num;
        logic [DIGIT_W-1:0] digits;
        logic               dollar;
        logic               esc_m;
        logic               caret;
        logic [7:0]         ch;
    } t_job;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // output sequence of one request
    typedef enum logic [2:0] {
        PH_NUM,
        PH_TAB,
        PH_DOLLAR,
        PH_M,
        PH_DASH,
        PH_CARET,
        PH_CHAR
    } t_phase;

    // saturating bcd increment, holds at all nines
    function automatic logic [DIGIT_W-1:0] bcd_inc(input logic [DIGIT_W-1:0] v);
        logic [DIGIT_W-1:0] r;
        logic               carry;
        logic               all_nine;
        r        = v;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[i*4 +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                if (v[i*4 +: 4] == 4'd9) begin
                    r[i*4 +: 4] = 4'd0;
                end else begin
                    r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all_nine ? v : r;
    endfunction

    // phase that follows the number and its tab
    function automatic t_phase phase_after_tab(input t_job j);
        t_phase p;
        if (j.dollar) begin
            p = PH_DOLLAR;
        end else if (j.esc_m) begin
            p = PH_M;
        end else if (j.caret) begin
            p = PH_CARET;
        end else begin
            p = PH_CHAR;
        end
        return p;
    endfunction

    // phase that follows the dollar sign
    function automatic t_phase phase_after_dollar(input t_job j);
        t_phase p;
        if (j.esc_m) begin
            p = PH_M;
        end else if (j.caret) begin
            p = PH_CARET;
        end else begin
            p = PH_CHAR;
        end
        return p;
    endfunction

    // first phase of a fresh request
    function automatic t_phase phase_first(input t_job j);
        return j.has_num ? PH_NUM : phase_after_tab(j);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/text_stream_line_formatter.sv -----
// Path: an accepted input byte goes through the job queue and the back end's job register into the output register.
// Throughput: the back end sends one byte per cycle unless the output stalls; an input byte
// that expands to more bytes holds the back end until its last one is sent, and the 2-entry
// job queue takes input meanwhile. Plain text runs at one input byte per cycle unless stalled.
// Reset (synchronous, active low): options cleared, line state at file start, queue and
// output register empty.
`default_nettype none

module text_stream_line_formatter
    import tslf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic       i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_new_file,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    logic    push;
    logic    pop;
    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_stat.full;

    // classification and line state
    tslf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_new_file  (i_new_file),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (front_job)
    );

    // job queue
    tslf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // byte expansion and output register
    tslf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ----- hdl/tslf_front.sv -----
// front end: configuration registers, line state and classification of each input byte
// depends on tslf_pkg
`default_nettype none

module tslf_front
    import tslf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic       i_cfg_data,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_new_file,
    input  wire t_q_stat    i_q_stat,
    output logic            o_push,
    output t_job            o_job
);

    t_cfg               r_cfg, n_cfg;
    logic [7:0]         r_prior, n_prior;
    logic [7:0]         r_bbp, n_bbp;
    logic               r_line_start, n_line_start;
    logic [DIGIT_W-1:0] r_all_cnt, n_all_cnt;
    logic [DIGIT_W-1:0] r_nb_cnt, n_nb_cnt;

    logic               acc;
    logic               nl;
    logic               squeeze;
    logic               use_all;
    logic               use_nb;
    logic               nonprint;
    logic [7:0]         low;
    logic [7:0]         e_prior;
    logic [7:0]         e_bbp;
    logic               e_line_start;
    logic [DIGIT_W-1:0] e_all_cnt;
    logic [DIGIT_W-1:0] e_nb_cnt;
    t_cfg_idx           cfg_idx;

    assign acc     = i_valid && !i_q_stat.full;
    assign nl      = (i_in_byte == CH_NL);
    assign cfg_idx = t_cfg_idx'(i_cfg_index);

    // line state seen by this byte, after an optional new-file reset
    always_comb begin
        e_prior      = i_new_file ? CH_NL : r_prior;
        e_bbp        = i_new_file ? CH_SPACE : r_bbp;
        e_line_start = i_new_file ? 1'b1 : r_line_start;
        e_all_cnt    = i_new_file ? DIGIT_W'(1) : r_all_cnt;
        e_nb_cnt     = i_new_file ? DIGIT_W'(1) : r_nb_cnt;
    end

    // classification
    always_comb begin
        squeeze  = r_cfg.squeeze_blank && nl && (e_prior == CH_NL) && (e_bbp == CH_NL);
        use_all  = r_cfg.number_all && !r_cfg.number_nonblank && e_line_start;
        use_nb   = r_cfg.number_nonblank && (e_prior == CH_NL) && !nl;
        nonprint = (i_in_byte <= CH_CTRL_LAST && i_in_byte != CH_TAB && !nl)
                   || (i_in_byte >= CH_DEL && i_in_byte <= CH_NP_LAST);
        low      = i_in_byte & ~CH_HIGH_BIT;

        o_job.has_num = use_all || use_nb;
        o_job.digits  = use_all ? e_all_cnt : e_nb_cnt;
        o_job.dollar  = r_cfg.show_ends && nl;
        o_job.esc_m   = 1'b0;
        o_job.caret   = 1'b0;
        o_job.ch      = i_in_byte;
        if (r_cfg.show_tabs && i_in_byte == CH_TAB) begin
            o_job.caret = 1'b1;
            o_job.ch    = CH_I;
        end else if (r_cfg.show_nonprinting && nonprint) begin
            o_job.esc_m = i_in_byte[7];
            o_job.caret = 1'b1;
            o_job.ch    = (low == CH_DEL) ? CH_QMARK : (low + CH_AT);
        end
        o_push = acc && !squeeze;
    end

    // next state of line tracking and configuration
    always_comb begin
        n_cfg        = r_cfg;
        n_prior      = r_prior;
        n_bbp        = r_bbp;
        n_line_start = r_line_start;
        n_all_cnt    = r_all_cnt;
        n_nb_cnt     = r_nb_cnt;
        if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_NUMBER_ALL:       n_cfg.number_all       = i_cfg_data;
                CFG_NUMBER_NONBLANK:  n_cfg.number_nonblank  = i_cfg_data;
                CFG_SHOW_ENDS:        n_cfg.show_ends        = i_cfg_data;
                CFG_SHOW_NONPRINTING: n_cfg.show_nonprinting = i_cfg_data;
                CFG_SQUEEZE_BLANK:    n_cfg.squeeze_blank    = i_cfg_data;
                CFG_SHOW_TABS:        n_cfg.show_tabs        = i_cfg_data;
                default: ;
            endcase
        end
        if (acc) begin
            n_prior      = e_prior;
            n_bbp        = e_bbp;
            n_line_start = e_line_start;
            n_all_cnt    = e_all_cnt;
            n_nb_cnt     = e_nb_cnt;
            if (!squeeze) begin
                n_bbp   = e_prior;
                n_prior = i_in_byte;
                if (r_cfg.number_all && !r_cfg.number_nonblank) begin
                    n_line_start = nl;
                end
                if (use_all) begin
                    n_all_cnt = bcd_inc(e_all_cnt);
                end
                if (use_nb) begin
                    n_nb_cnt = bcd_inc(e_nb_cnt);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_prior      <= CH_NL;
            r_bbp        <= CH_SPACE;
            r_line_start <= 1'b1;
            r_all_cnt    <= DIGIT_W'(1);
            r_nb_cnt     <= DIGIT_W'(1);
        end else begin
            r_cfg        <= n_cfg;
            r_prior      <= n_prior;
            r_bbp        <= n_bbp;
            r_line_start <= n_line_start;
            r_all_cnt    <= n_all_cnt;
            r_nb_cnt     <= n_nb_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tslf_fifo.sv -----
// short job queue between the front and back ends, held in flip-flops
// depends on tslf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tslf_fifo
    import tslf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `ASSERT_NEVER(a_q_overflow, i_push && o_stat.full && !i_pop, "job queue overflow")
    `ASSERT_NEVER(a_q_underflow, i_pop && o_stat.empty, "pop from empty job queue")
    `ASSERT_HOLDS(a_q_count, r_count <= QUEUE_CW'(QUEUE_DEPTH), "job queue count out of range")

endmodule

`default_nettype wire

// ----- hdl/tslf_back.sv -----
// back end: expands one queued job into output bytes, one per cycle while not stalled, into an output register
// depends on tslf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tslf_back
    import tslf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire t_q_stat i_q_stat,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic                  r_cur_valid, n_cur_valid;
    t_job                  r_job, n_job;
    t_phase                r_phase, n_phase;
    logic [DIG_CNT_W-1:0]  r_dig_cnt, n_dig_cnt;
    logic                  r_seen, n_seen;
    logic [EMIT_CNT_W-1:0] r_emit_cnt, n_emit_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte, n_out_byte;
    logic                  r_out_last, n_out_last;

    logic       emit;
    logic       last;
    logic [3:0] digit;
    logic       blank;
    logic [7:0] cur_byte;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    // byte of the current phase
    always_comb begin
        digit = r_job.digits[DIGIT_W-1 -: 4];
        blank = (digit == 4'd0) && !r_seen && (r_dig_cnt != '0);
        unique case (r_phase)
            PH_NUM:    cur_byte = blank ? CH_SPACE : (CH_ZERO + {4'd0, digit});
            PH_TAB:    cur_byte = CH_TAB;
            PH_DOLLAR: cur_byte = CH_DOLLAR;
            PH_M:      cur_byte = CH_M;
            PH_DASH:   cur_byte = CH_DASH;
            PH_CARET:  cur_byte = CH_CARET;
            PH_CHAR:   cur_byte = r_job.ch;
            default:   cur_byte = r_job.ch;
        endcase
        emit = r_cur_valid && (!r_out_valid || !i_stall);
        last = (r_phase == PH_CHAR) || (r_emit_cnt == EMIT_CNT_W'(MAX_RESULTS - 1));
        o_pop = (!r_cur_valid || (emit && last)) && !i_q_stat.empty;
    end

    // sequencer next state
    always_comb begin
        n_cur_valid = r_cur_valid;
        n_job       = r_job;
        n_phase     = r_phase;
        n_dig_cnt   = r_dig_cnt;
        n_seen      = r_seen;
        n_emit_cnt  = r_emit_cnt;
        if (emit) begin
            n_emit_cnt = r_emit_cnt + 1'b1;
            unique case (r_phase)
                PH_NUM: begin
                    n_seen       = r_seen || (digit != 4'd0);
                    n_job.digits = r_job.digits << 4;
                    n_dig_cnt    = r_dig_cnt - 1'b1;
                    if (r_dig_cnt == '0) begin
                        n_phase = PH_TAB;
                    end
                end
                PH_TAB:    n_phase = phase_after_tab(r_job);
                PH_DOLLAR: n_phase = phase_after_dollar(r_job);
                PH_M:      n_phase = PH_DASH;
                PH_DASH:   n_phase = PH_CARET;
                PH_CARET:  n_phase = PH_CHAR;
                PH_CHAR:   n_phase = PH_CHAR;
                default:   n_phase = PH_CHAR;
            endcase
            if (last) begin
                n_cur_valid = 1'b0;
            end
        end
        if (o_pop) begin
            n_cur_valid = 1'b1;
            n_job       = i_job;
            n_phase     = phase_first(i_job);
            n_dig_cnt   = DIG_CNT_W'(NUMBER_DIGITS - 1);
            n_seen      = 1'b0;
            n_emit_cnt  = '0;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_last  = last;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_phase     <= PH_CHAR;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_dig_cnt  <= n_dig_cnt;
        r_seen     <= n_seen;
        r_emit_cnt <= n_emit_cnt;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    `ASSERT_NEVER(a_emit_cap, r_cur_valid && (r_emit_cnt >= EMIT_CNT_W'(MAX_RESULTS)),
        "run longer than the result cap")
    `ASSERT_HOLDS(a_last_frees, (emit && last && !o_pop) |=> !r_cur_valid,
        "job still active after its last byte")
    `ASSERT_HOLDS(a_char_last, (r_cur_valid && r_phase == PH_CHAR && emit) |=> r_out_last,
        "final character not marked last")

endmodule

`default_nettype wire
